>>> design/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the minimum-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned VALUE_BITS  = 30;
  localparam int unsigned ADDR_BITS   = $clog2(STACK_DEPTH);
  localparam int unsigned COUNT_BITS  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ENTRY_BITS  = 9;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_MIN  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the incoming beat
    logic execute;  // apply the operation and load the result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // result register empty or being drained this cycle
  } dp_status_t;

endpackage

>>> design/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// Controller: takes one beat, moves to S_EXEC while the store read completes,
// then hands the operation to the datapath once the result register is free.
// ----------------------------------------------------------------------------
module mts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mts_pkg::dp_status_t status_i,
  output mts_pkg::ctrl_cmd_t  cmd_o
);
  import mts_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;

  always_comb begin
    state_d       = state_q;
    stall_d       = stall_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
          stall_d       = 1'b1;
        end
      end
      S_EXEC: begin
        if (status_i.out_free) begin
          cmd_o.execute = 1'b1;
          state_d       = S_IDLE;
          stall_d       = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
        stall_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;

endmodule

>>> design/mts_dp.sv
// ----------------------------------------------------------------------------
// mts_dp
// Datapath: entry counter, value and minimum stores, operation logic and
// the result register.
// ----------------------------------------------------------------------------
module mts_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mts_pkg::ctrl_cmd_t                  cmd_i,
  output mts_pkg::dp_status_t                 status_o,
  input  logic [1:0]                          operation_i,
  input  logic [mts_pkg::VALUE_BITS-1:0]      push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mts_pkg::VALUE_BITS-1:0]      result_value_o,
  output logic [1:0]                          status_code_o,
  output logic [mts_pkg::ENTRY_BITS-1:0]      entry_count_o
);
  import mts_pkg::*;

  // captured beat
  op_e                   op_q;
  logic [VALUE_BITS-1:0] val_q;

  logic [COUNT_BITS-1:0] count_q, count_d, count_m1;

  // store ports
  logic                  we;
  logic [ADDR_BITS-1:0]  waddr, raddr;
  logic [VALUE_BITS-1:0] wr_min, rd_val, rd_min;

  // result register
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] res_q, res_d;
  status_e               st_q, st_d;
  logic [ENTRY_BITS-1:0] cnt_out_q, cnt_out_d;

  logic empty, full;

  assign count_m1 = count_q - COUNT_BITS'(1);
  // top entry is read continuously; count only moves on execute
  assign raddr    = count_m1[ADDR_BITS-1:0];
  assign waddr    = count_q[ADDR_BITS-1:0];
  assign empty    = (count_q == '0);
  assign full     = (count_q == COUNT_BITS'(STACK_DEPTH));
  assign wr_min   = (!empty && (rd_min < val_q)) ? rd_min : val_q;

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  mts_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (val_q),
    .raddr_i (raddr),
    .rdata_o (rd_val)
  );

  mts_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_min_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wr_min),
    .raddr_i (raddr),
    .rdata_o (rd_min)
  );

  always_comb begin
    we          = 1'b0;
    count_d     = count_q;
    res_d       = res_q;
    st_d        = st_q;
    cnt_out_d   = cnt_out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.execute) begin
      res_d       = '0;
      st_d        = ST_OK;
      out_valid_d = 1'b1;
      unique case (op_q)
        OP_PUSH: begin
          if (full) begin
            st_d = ST_FULL;
          end else begin
            we      = 1'b1;
            count_d = count_q + COUNT_BITS'(1);
          end
        end
        OP_POP, OP_PEEK, OP_MIN: begin
          if (empty) begin
            st_d = ST_EMPTY;
          end else begin
            res_d = (op_q == OP_MIN) ? rd_min : rd_val;
            if (op_q == OP_POP) begin
              count_d = count_m1;
            end
          end
        end
        default: ;
      endcase
      cnt_out_d = ENTRY_BITS'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(operation_i);
      val_q <= push_value_i;
    end
    res_q     <= res_d;
    st_q      <= st_d;
    cnt_out_q <= cnt_out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign status_code_o  = st_q;
  assign entry_count_o  = cnt_out_q;

endmodule

>>> design/min_tracking_stack_top.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_top
// LIFO stack that keeps the running minimum beside every entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one operation per beat:
//   push, pop, peek top or read minimum. Output channel (out_valid_o /
//   out_stall_i) returns exactly one result beat per input beat, in order.
//   A beat moves on a rising edge with valid high and stall low.
// Timing:
//   A taken beat is captured and the controller moves to S_EXEC; the
//   operation executes and loads the result register once that register is
//   free. One operation is in flight at a time; the store read of the top
//   entry (registered RAM output) keeps a new beat out until the last executes.
// Reset:
//   rst_ni (asynchronous, active low) empties the stack and drops any
//   pending result. Store contents are not cleared; only entries below the
//   count are ever used.
// Backpressure:
//   A result waits in the output register while out_stall_i is high; the
//   next beat can be taken meanwhile but is held until the register frees.
// ----------------------------------------------------------------------------
module min_tracking_stack_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     operation_i,
  input  logic [mts_pkg::VALUE_BITS-1:0] push_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mts_pkg::VALUE_BITS-1:0] result_value_o,
  output logic [1:0]                     status_o,
  output logic [mts_pkg::ENTRY_BITS-1:0] entry_count_o
);
  import mts_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // sequencing: capture beat, then execute on the top entry
  mts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // stores, counter and result register
  mts_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .operation_i    (operation_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .status_code_o  (status_o),
    .entry_count_o  (entry_count_o)
  );

  // Only one operation in flight: a taken beat stalls the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("beat taken while previous operation still in flight");

  // Count never passes the stack depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (entry_count_o <= ENTRY_BITS'(STACK_DEPTH)))
    else $error("entry count beyond stack depth");

  // Empty status only with an empty stack, and with a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_EMPTY)) |->
      ((entry_count_o == '0) && (result_value_o == '0)))
    else $error("empty status with entries or non-zero value");

  // Full status only when the stack holds every entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL)) |->
      ((entry_count_o == ENTRY_BITS'(STACK_DEPTH)) && (result_value_o == '0)))
    else $error("full status on a stack that is not full");

endmodule

>>> tb/sv/min_tracking_stack_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_checker
// Watches both channels of the minimum-tracking stack, keeps its own copy of
// the stack and compares every result beat with the reply it predicts.
// ----------------------------------------------------------------------------
module min_tracking_stack_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [1:0]                     operation_i,
  input  logic [mts_pkg::VALUE_BITS-1:0] push_value_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [mts_pkg::VALUE_BITS-1:0] result_value_i,
  input  logic [1:0]                     status_i,
  input  logic [mts_pkg::ENTRY_BITS-1:0] entry_count_i,
  output int unsigned                    mismatches_o,
  output int unsigned                    replies_owed_o
);
  import mts_pkg::*;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    status_e               status;
    logic [ENTRY_BITS-1:0] count;
  } stack_reply_t;

  // Shadow stack: pushed values and the running minimum at each level.
  logic [VALUE_BITS-1:0] value_stack [STACK_DEPTH];
  logic [VALUE_BITS-1:0] floor_min   [STACK_DEPTH];
  int unsigned           depth;
  stack_reply_t          replies_due [$];

  function automatic stack_reply_t stack_apply(input op_e op, input logic [VALUE_BITS-1:0] v);
    stack_reply_t          r;
    logic [VALUE_BITS-1:0] m;
    r.value  = '0;
    r.status = ST_OK;
    if (op == OP_PUSH) begin
      if (depth >= STACK_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        m = v;
        if (depth > 0 && floor_min[depth-1] < m) m = floor_min[depth-1];
        value_stack[depth] = v;
        floor_min[depth]   = m;
        depth++;
      end
    end else if (depth == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.value = (op == OP_MIN) ? floor_min[depth-1] : value_stack[depth-1];
      if (op == OP_POP) depth--;
    end
    r.count = ENTRY_BITS'(depth);
    return r;
  endfunction

  task automatic log_mismatch(input string what, input stack_reply_t want);
    mismatches_o++;
    if (mismatches_o <= 10) begin
      $write("%0t: %s: expected value %h status %0d count %0d, ",
             $realtime, what, want.value, want.status, want.count);
      $display("got value %h status %0d count %0d",
               result_value_i, status_i, entry_count_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stack_reply_t want;
    if (!rst_ni) begin
      depth = 0;
      replies_due.delete();
      mismatches_o   = 0;
      replies_owed_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        replies_due.push_back(stack_apply(op_e'(operation_i), push_value_i));
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          log_mismatch("unexpected result beat", '0);
        end else begin
          want = replies_due.pop_front();
          if (want.value !== result_value_i || want.status !== status_i ||
              want.count !== entry_count_i)
            log_mismatch("result mismatch", want);
        end
      end
      replies_owed_o = replies_due.size();
    end
  end

endmodule

>>> tb/sv/min_tracking_stack_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_top_tb
// Drives the minimum-tracking stack with a directed opening and a long run of
// fill / drain / mixed phases under random gaps and back-pressure; the checker
// beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module min_tracking_stack_top_tb;
  import mts_pkg::*;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  // stimulus phases: fill to overflow, drain past empty, then an even mix
  typedef enum logic [1:0] {
    PH_MIX,
    PH_FILL,
    PH_DRAIN
  } phase_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [1:0]            operation_i;
  logic [VALUE_BITS-1:0] push_value_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [VALUE_BITS-1:0] result_value_o;
  logic [1:0]            status_o;
  logic [ENTRY_BITS-1:0] entry_count_o;

  int unsigned mismatches;
  int unsigned replies_owed;

  // stimulus-side view of the fill level, used only to steer the phases
  int unsigned fill_level;
  int unsigned sent_beats;
  bit          sender_calm;

  min_tracking_stack_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o)
  );

  min_tracking_stack_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .operation_i    (operation_i),
    .push_value_i   (push_value_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_i (result_value_o),
    .status_i       (status_o),
    .entry_count_i  (entry_count_o),
    .mismatches_o   (mismatches),
    .replies_owed_o (replies_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Idle cycles before a beat (sender) or a stall spell (receiver). A calm
  // stretch gives back-to-back traffic; otherwise mostly short waits with the
  // odd long one so gaps land at every point of the S_IDLE / S_EXEC sequence.
  function automatic int unsigned draw_wait(input bit calm);
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 12);
    return $urandom_range(0, 3);
  endfunction

  // Mix of tiny values (lots of ties and new minimums), the extremes and
  // fully random words so every bit of the value sees both levels.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return VALUE_BITS'($urandom_range(0, 15));
      1:       return VALUE_MAX - VALUE_BITS'($urandom_range(0, 15));
      2:       return '0;
      3:       return VALUE_MAX;
      default: return VALUE_BITS'($urandom());
    endcase
  endfunction

  // One input beat. Valid is only dropped when an idle gap follows, so a
  // back-to-back beat never sees valid lowered and raised in the same step.
  task automatic send_op(input op_e op, input logic [VALUE_BITS-1:0] v);
    int unsigned gap;
    if (sent_beats % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    gap = draw_wait(sender_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    push_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    sent_beats++;
    case (op)
      OP_PUSH: if (fill_level < STACK_DEPTH) fill_level++;
      OP_POP:  if (fill_level > 0) fill_level--;
      default: ;
    endcase
  endtask

  // Receiver: a random stall spell per result beat, then stall low until the
  // beat is taken. The spell may start before the result shows up.
  initial begin
    int unsigned spell;
    int unsigned taken;
    bit          calm;
    out_stall_i <= 1'b0;
    taken = 0;
    calm  = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      spell = draw_wait(calm);
      if (spell > 0) begin
        out_stall_i <= 1'b1;
        repeat (spell) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #500us;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    phase_e      phase;
    int unsigned overflow_hits;
    int unsigned underflow_hits;
    int unsigned mix_left;
    op_e         op;

    in_valid_i    <= 1'b0;
    operation_i   <= OP_PUSH;
    push_value_i  <= '0;
    rst_ni        <= 1'b0;
    fill_level     = 0;
    sent_beats     = 0;
    sender_calm    = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed opening -------------------------------------------------
    // reads on an empty stack
    send_op(OP_POP,  '0);
    send_op(OP_PEEK, '0);
    send_op(OP_MIN,  '0);
    // largest value, then zero drops the minimum, then a value above it
    send_op(OP_PUSH, VALUE_MAX);
    send_op(OP_PEEK, '0);
    send_op(OP_MIN,  '0);
    send_op(OP_PUSH, '0);
    send_op(OP_MIN,  '0);
    send_op(OP_PUSH, VALUE_BITS'(5));
    send_op(OP_PEEK, '0);
    send_op(OP_MIN,  '0);
    // popping must restore the older minimum
    send_op(OP_POP,  '0);
    send_op(OP_POP,  '0);
    send_op(OP_MIN,  '0);
    // equal value pushed on top, push_value ignored by a pop
    send_op(OP_PUSH, VALUE_MAX);
    send_op(OP_MIN,  VALUE_MAX);
    send_op(OP_POP,  VALUE_MAX);
    send_op(OP_POP,  '0);
    send_op(OP_MIN,  '0);
    // minimum in the middle of the stack
    send_op(OP_PUSH, VALUE_BITS'(7));
    send_op(OP_PUSH, VALUE_BITS'(3));
    send_op(OP_PUSH, VALUE_BITS'(9));
    send_op(OP_MIN,  '0);
    send_op(OP_POP,  '0);

    // --- random phases ----------------------------------------------------
    // Fill runs until several pushes have been refused on a full stack,
    // drain until several reads have hit the empty stack, then a mixed spell.
    phase          = PH_MIX;
    mix_left       = 60;
    overflow_hits  = 0;
    underflow_hits = 0;
    for (int n = 0; n < 850; n++) begin
      case (phase)
        PH_FILL:  op = ($urandom_range(0, 99) < 80) ? OP_PUSH : op_e'($urandom_range(0, 3));
        PH_DRAIN: op = ($urandom_range(0, 99) < 80) ? OP_POP  : op_e'($urandom_range(0, 3));
        default:  op = op_e'($urandom_range(0, 3));
      endcase
      if (op == OP_PUSH && fill_level == STACK_DEPTH) overflow_hits++;
      if (op != OP_PUSH && fill_level == 0) underflow_hits++;
      send_op(op, (op == OP_PUSH || $urandom_range(0, 1)) ? pick_value() : '0);
      case (phase)
        PH_FILL: if (overflow_hits >= 4) begin
          phase          = PH_DRAIN;
          underflow_hits = 0;
        end
        PH_DRAIN: if (underflow_hits >= 4) begin
          phase    = PH_MIX;
          mix_left = 80;
        end
        default: if (--mix_left == 0) begin
          phase         = PH_FILL;
          overflow_hits = 0;
        end
      endcase
    end
    in_valid_i <= 1'b0;

    // drain outstanding results, then wait for anything stray;
    // the checker's count is read away from the sampling edge
    @(negedge clk_i);
    while (replies_owed != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/mts_pkg.sv
design/mts_ram.sv
design/mts_ctrl.sv
design/mts_dp.sv
design/min_tracking_stack_top.sv
tb/sv/min_tracking_stack_checker.sv
tb/sv/min_tracking_stack_top_tb.sv
